@@ design/iss_pkg.sv @@
// shared types and constants for the insertion sorter with statistics
`timescale 1ns / 1ps

package iss_pkg;

  localparam int unsigned VAL_W = 32;
  localparam int unsigned CMP_W = 9;
  localparam int unsigned MOV_W = 10;
  localparam int unsigned ACC_W = 11;
  localparam logic [CMP_W-1:0] CMP_MAX = 9'd511;
  localparam logic [MOV_W-1:0] MOV_MAX = 10'd1023;

  // what one cell sees of its neighbour
  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    valid;
    logic                    shift;
  } link_t;

  typedef struct packed {
    logic ins;
    logic drain;
  } cell_ctrl_t;

  typedef struct packed {
    logic ins;
    logic drop;
    logic clear;
  } stat_ctrl_t;

endpackage

@@ design/iss_cell.sv @@
// one cell of the sorting chain: holds a value, shifts up on insert, down on drain
`timescale 1ns / 1ps

module iss_cell
  import iss_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cell_ctrl_t              ctrl_i,
  input  logic signed [VAL_W-1:0] key_i,
  input  link_t                   left_i,
  input  link_t                   right_i,
  output link_t                   link_o
);

  logic signed [VAL_W-1:0] value_q, value_d;
  logic                    valid_q, valid_d;
  logic                    shift;

  // an empty cell behaves as +inf, so the key lands after equal values
  assign shift = !valid_q || (value_q > key_i);

  always_comb begin
    value_d = value_q;
    valid_d = valid_q;
    if (ctrl_i.drain) begin
      value_d = right_i.value;
      valid_d = right_i.valid;
    end else if (ctrl_i.ins) begin
      if (shift) begin
        value_d = left_i.shift ? left_i.value : key_i;
      end
      valid_d = valid_q | left_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign link_o.value = value_q;
  assign link_o.valid = valid_q;
  assign link_o.shift = shift;

endmodule

@@ design/iss_stats.sv @@
// occupancy, comparison and move counters, overflow flag
`timescale 1ns / 1ps

module iss_stats
  import iss_pkg::*;
#(
  parameter int unsigned DEPTH = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  stat_ctrl_t                       ctrl_i,
  input  logic [DEPTH-1:0]                 shift_i,
  output logic [$clog2(DEPTH+1)-1:0]       occ_o,
  output logic                             full_o,
  output logic [CMP_W-1:0]                 cmp_sum_o,
  output logic [MOV_W-1:0]                 mov_sum_o,
  output logic                             ovf_o
);

  localparam int unsigned OCC_W = $clog2(DEPTH+1);

  logic [OCC_W-1:0] occ_q, occ_d;
  logic [CMP_W-1:0] cmp_q, cmp_d;
  logic [MOV_W-1:0] mov_q, mov_d;
  logic             ovf_q, ovf_d;

  logic [OCC_W-1:0] pos;
  logic [OCC_W-1:0] greater;
  logic [ACC_W-1:0] cmp_sum, mov_sum;

  // the shift flags form a thermometer; its edge gives the insert position
  always_comb begin
    pos = '0;
    for (int k = 0; k < DEPTH; k++) begin
      if (shift_i[k] && (k == 0 || !shift_i[(k == 0) ? 0 : k-1])) begin
        pos = pos | OCC_W'(k);
      end
    end
  end

  assign greater = occ_q - pos;
  assign cmp_sum = ACC_W'(cmp_q) + ACC_W'(greater) + ACC_W'(pos != '0);
  assign mov_sum = ACC_W'(mov_q) + ACC_W'(greater) + ACC_W'(2);

  always_comb begin
    occ_d = occ_q;
    cmp_d = cmp_q;
    mov_d = mov_q;
    ovf_d = ovf_q;
    priority if (ctrl_i.clear) begin
      occ_d = '0;
      cmp_d = '0;
      mov_d = '0;
      ovf_d = 1'b0;
    end else if (ctrl_i.drop) begin
      ovf_d = 1'b1;
    end else if (ctrl_i.ins) begin
      occ_d = occ_q + OCC_W'(1);
      // first item of a run counts nothing
      if (occ_q != '0) begin
        cmp_d = (cmp_sum >= ACC_W'(CMP_MAX)) ? CMP_MAX : cmp_sum[CMP_W-1:0];
        mov_d = (mov_sum >= ACC_W'(MOV_MAX)) ? MOV_MAX : mov_sum[MOV_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
      cmp_q <= '0;
      mov_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
      cmp_q <= cmp_d;
      mov_q <= mov_d;
      ovf_q <= ovf_d;
    end
  end

  assign occ_o     = occ_q;
  assign full_o    = (occ_q == OCC_W'(DEPTH));
  assign cmp_sum_o = cmp_q;
  assign mov_sum_o = mov_q;
  assign ovf_o     = ovf_q;

endmodule

@@ design/insertion_sorter_with_stats_unit.sv @@
// insertion sorter top level: cell chain, statistics and stream ports
// loading: one value accepted per cycle, inserted by the chain in the same cycle unless full
// after the transaction marked last, the run drains from cell 0, one result per cycle while the
// sink is ready, the first result valid the cycle after; n stored values take n output transactions
// no input is taken while the run drains; the chain shift sets both rates
// reset clears valid bits, occupancy, counters and the overflow flag; cell data is not reset
`timescale 1ns / 1ps

module insertion_sorter_with_stats_unit
  import iss_pkg::*;
#(
  parameter int unsigned DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // value[31:0]
  input  logic        s_axis_tlast_i,   // is_final
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // sorted_value[31:0], compare_total[40:32], move_total[50:41], overflowed[51], zero[55:52]
  output logic [55:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o    // end_of_run
);

  localparam int unsigned OCC_W = $clog2(DEPTH+1);

  logic drain_q, drain_d;
  logic in_fire, out_fire, full;

  link_t            lnk [DEPTH];
  logic [DEPTH-1:0] shift_vec;
  logic [DEPTH-1:0] valid_vec;
  cell_ctrl_t       cell_ctrl;
  stat_ctrl_t       stat_ctrl;

  logic [OCC_W-1:0] occ;
  logic [CMP_W-1:0] cmp_sum;
  logic [MOV_W-1:0] mov_sum;
  logic             ovf;

  assign s_axis_tready_o = !drain_q;
  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_fire = m_axis_tvalid_o && m_axis_tready_i;

  assign cell_ctrl.ins   = in_fire && !full;
  assign cell_ctrl.drain = out_fire;

  assign stat_ctrl.ins   = in_fire && !full;
  assign stat_ctrl.drop  = in_fire && full;
  assign stat_ctrl.clear = out_fire && m_axis_tlast_o;

  always_comb begin
    drain_d = drain_q;
    if (in_fire && s_axis_tlast_i) begin
      drain_d = 1'b1;
    end else if (out_fire && m_axis_tlast_o) begin
      drain_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drain_q <= 1'b0;
    end else begin
      drain_q <= drain_d;
    end
  end

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    link_t left, right;

    if (k == 0) begin : g_first
      assign left = '{value: '0, valid: 1'b1, shift: 1'b0};
    end else begin : g_mid_l
      assign left = lnk[k-1];
    end

    if (k == DEPTH-1) begin : g_last
      assign right = '{value: '0, valid: 1'b0, shift: 1'b0};
    end else begin : g_mid_r
      assign right = lnk[k+1];
    end

    iss_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (cell_ctrl),
      .key_i   ($signed(s_axis_tdata_i)),
      .left_i  (left),
      .right_i (right),
      .link_o  (lnk[k])
    );

    assign shift_vec[k] = lnk[k].shift;
    assign valid_vec[k] = lnk[k].valid;
  end

  iss_stats #(
    .DEPTH (DEPTH)
  ) u_stats (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (stat_ctrl),
    .shift_i   (shift_vec),
    .occ_o     (occ),
    .full_o    (full),
    .cmp_sum_o (cmp_sum),
    .mov_sum_o (mov_sum),
    .ovf_o     (ovf)
  );

  assign m_axis_tvalid_o = drain_q && valid_vec[0];
  assign m_axis_tlast_o  = drain_q && ((DEPTH > 1) ? !valid_vec[1] : 1'b1);
  assign m_axis_tdata_o  = {4'b0, ovf, mov_sum, cmp_sum, lnk[0].value};

  // input and drain never overlap
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !s_axis_tready_o)
    else $error("input ready while draining");

  // a dropped item only happens on a full store
  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf |-> (occ == OCC_W'(DEPTH)))
    else $error("overflow flag set with free cells");

  a_occ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ <= OCC_W'(DEPTH))
    else $error("occupancy above depth");

  // valid cells always form a prefix of the chain
  a_valid_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((valid_vec >> 1) & ~valid_vec) == '0)
    else $error("gap in the cell chain");

  a_run_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && m_axis_tlast_o) |=>
      (cmp_sum == '0 && mov_sum == '0 && !ovf && occ == '0 && !valid_vec[0]))
    else $error("run state not cleared after last result");

endmodule
